### rtl/core/pce_pkg.sv
// Shared types and constants for the point charge field evaluator.
package pce_pkg;

   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_ADD   = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   localparam logic [9:0] RADIUS_RESET = 10'd10;

   localparam int SQRT_STEPS = 48;
   localparam int MUL_STEPS  = 48;
   localparam int DIV_STEPS  = 64;

   localparam int REC_W = 48;

   localparam logic signed [55:0] SAT_HI = 56'sh00_7FFF_FFFF_FFFF;
   localparam logic signed [55:0] SAT_LO = -56'sh00_8000_0000_0000;

   typedef struct packed {
      logic tbl;
      logic wr_pos;
      logic wr_neg;
      logic q_start;
      logic ld;
      logic sq1;
      logic sq2;
      logic sqrt_ld_chg;
      logic sqrt_ld_hyp;
      logic sqrt_step;
      logic mul_ld_chg;
      logic mul_ld_hx;
      logic mul_ld_hy;
      logic mul_step;
      logic div_ld_chg;
      logic div_ld_dir;
      logic div_step;
      logic acc;
      logic sat;
      logic mag_ld;
      logic out_ld;
   } cmd_type;

   typedef struct packed {
      logic r2_zero;
      logic mag_zero;
   } stat_type;

endpackage

### rtl/core/pce_ram.sv
// Generic single write port, single read port RAM with registered read.
module pce_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### rtl/core/pce_datapath.sv
// Datapath: charge tables, per-charge term arithmetic, accumulators and outputs.
module pce_datapath import pce_pkg::*; #(
   parameter int MAX_CHARGES = 32,
   localparam int AW = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic [9:0]         csr_near_radius,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_charge_value,
   input  cmd_type            cmd,
   input  logic [AW-1:0]      wr_addr,
   input  logic [AW-1:0]      rd_addr,
   output stat_type           stat,
   output logic signed [47:0] rsp_field_x,
   output logic signed [47:0] rsp_field_y,
   output logic [46:0]        rsp_field_mag,
   output logic signed [15:0] rsp_dir_cos,
   output logic signed [15:0] rsp_dir_sin,
   output logic               rsp_singular,
   output logic               rsp_near_pos_hit,
   output logic signed [15:0] rsp_near_pos_x,
   output logic signed [15:0] rsp_near_pos_y,
   output logic               rsp_near_neg_hit,
   output logic signed [15:0] rsp_near_neg_x,
   output logic signed [15:0] rsp_near_neg_y
);
   logic [REC_W-1:0] wdata, pos_rdata, neg_rdata, rec;

   assign wdata = {req_pos_x, req_pos_y, req_charge_value};

   pce_ram #(.WIDTH(REC_W), .DEPTH(MAX_CHARGES)) u_pos_ram (
      .clock(clock), .we(cmd.wr_pos), .waddr(wr_addr), .wdata(wdata),
      .raddr(rd_addr), .rdata(pos_rdata)
   );

   pce_ram #(.WIDTH(REC_W), .DEPTH(MAX_CHARGES)) u_neg_ram (
      .clock(clock), .we(cmd.wr_neg), .waddr(wr_addr), .wdata(wdata),
      .raddr(rd_addr), .rdata(neg_rdata)
   );

   assign rec = cmd.tbl ? neg_rdata : pos_rdata;

   logic [9:0]  radius_ff;
   logic [19:0] rad2_ff;
   logic signed [15:0] qx_ff, qy_ff;
   logic signed [15:0] chx_ff, chy_ff, chq_ff;
   logic signed [16:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [16:0] adx, ady;
   logic [15:0] aq;
   logic [33:0] sqx_ff, r2_ff, r2_in;
   logic [32:0] numx_ff, numy_ff;
   logic        negx_ff, negy_ff;

   // iterative units
   logic [95:0] sq_n_ff;
   logic [50:0] sq_rem_ff, sq_rem_t, sq_trial;
   logic [47:0] sq_root_ff;
   logic [95:0] mul_a_ff, prod_ff;
   logic [47:0] mul_b_ff;
   logic [63:0] dvs_ff, dvdx_ff, dvdy_ff, remx_ff, remy_ff;
   logic [63:0] remx_t, remy_t;
   logic        gex, gey;

   logic signed [55:0] accx_ff, accy_ff, tx, ty;
   logic signed [47:0] ex_ff, ey_ff;
   logic [47:0] abs_ex, abs_ey;
   logic [46:0] mag_ff;
   logic        sing_ff, phit_ff, nhit_ff;
   logic signed [15:0] phx_ff, phy_ff, nhx_ff, nhy_ff;
   logic        near;

   assign dx_in = {qx_ff[15], qx_ff} - {rec[47], rec[47:32]};
   assign dy_in = {qy_ff[15], qy_ff} - {rec[31], rec[31:16]};
   assign adx = dx_ff[16] ? 17'(-dx_ff) : dx_ff;
   assign ady = dy_ff[16] ? 17'(-dy_ff) : dy_ff;
   assign aq  = chq_ff[15] ? 16'(-chq_ff) : chq_ff;
   assign r2_in = sqx_ff + 34'(ady * ady);
   assign near = (r2_in < 34'(rad2_ff)) && !(cmd.tbl ? nhit_ff : phit_ff);

   assign sq_rem_t = {sq_rem_ff[48:0], sq_n_ff[95:94]};
   assign sq_trial = {1'b0, sq_root_ff, 2'b01};

   assign remx_t = {remx_ff[62:0], dvdx_ff[63]};
   assign remy_t = {remy_ff[62:0], dvdy_ff[63]};
   assign gex = remx_t >= dvs_ff;
   assign gey = remy_t >= dvs_ff;

   assign tx = negx_ff ? -$signed(dvdx_ff[55:0]) : $signed(dvdx_ff[55:0]);
   assign ty = negy_ff ? -$signed(dvdy_ff[55:0]) : $signed(dvdy_ff[55:0]);

   assign abs_ex = ex_ff[47] ? 48'(-ex_ff) : ex_ff;
   assign abs_ey = ey_ff[47] ? 48'(-ey_ff) : ey_ff;

   function automatic logic signed [47:0] sat48(input logic signed [55:0] v);
      if (v > SAT_HI) return SAT_HI[47:0];
      if (v < SAT_LO) return SAT_LO[47:0];
      return v[47:0];
   endfunction

   function automatic logic signed [15:0] dir_q15(input logic neg, input logic [63:0] r,
                                                  input logic zero);
      if (zero) return 16'sd0;
      if (neg) return (r >= 64'd32768) ? -16'sd32768 : 16'(-r[15:0]);
      return (r >= 64'd32767) ? 16'sd32767 : $signed(r[15:0]);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_valid) begin
         radius_ff <= csr_near_radius;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.q_start) begin
         qx_ff   <= req_pos_x;
         qy_ff   <= req_pos_y;
         rad2_ff <= radius_ff * radius_ff;
         accx_ff <= '0;
         accy_ff <= '0;
         sing_ff <= 1'b0;
         phit_ff <= 1'b0;
         nhit_ff <= 1'b0;
         phx_ff  <= '0;
         phy_ff  <= '0;
         nhx_ff  <= '0;
         nhy_ff  <= '0;
      end
      if (cmd.ld) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         chx_ff <= rec[47:32];
         chy_ff <= rec[31:16];
         chq_ff <= rec[15:0];
      end
      if (cmd.sq1) begin
         sqx_ff  <= 34'(adx * adx);
         numx_ff <= aq * adx;
         negx_ff <= chq_ff[15] ^ dx_ff[16];
      end
      if (cmd.sq2) begin
         r2_ff   <= r2_in;
         numy_ff <= aq * ady;
         negy_ff <= chq_ff[15] ^ dy_ff[16];
         if (r2_in == '0) sing_ff <= 1'b1;
         if (near && !cmd.tbl) begin
            phit_ff <= 1'b1;
            phx_ff  <= chx_ff;
            phy_ff  <= chy_ff;
         end
         if (near && cmd.tbl) begin
            nhit_ff <= 1'b1;
            nhx_ff  <= chx_ff;
            nhy_ff  <= chy_ff;
         end
      end

      // square root, one result bit per step
      if (cmd.sqrt_ld_chg || cmd.sqrt_ld_hyp) begin
         sq_n_ff    <= cmd.sqrt_ld_hyp ? prod_ff : {46'd0, r2_ff, 16'd0};
         sq_rem_ff  <= '0;
         sq_root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         sq_n_ff <= {sq_n_ff[93:0], 2'b00};
         if (sq_rem_t >= sq_trial) begin
            sq_rem_ff  <= sq_rem_t - sq_trial;
            sq_root_ff <= {sq_root_ff[46:0], 1'b1};
         end else begin
            sq_rem_ff  <= sq_rem_t;
            sq_root_ff <= {sq_root_ff[46:0], 1'b0};
         end
      end

      // shift-add multiplier; hy load keeps the product to sum two squares
      if (cmd.mul_ld_chg) begin
         mul_a_ff <= {62'd0, r2_ff};
         mul_b_ff <= sq_root_ff;
         prod_ff  <= '0;
      end else if (cmd.mul_ld_hx) begin
         mul_a_ff <= {48'd0, abs_ex};
         mul_b_ff <= abs_ex;
         prod_ff  <= '0;
      end else if (cmd.mul_ld_hy) begin
         mul_a_ff <= {48'd0, abs_ey};
         mul_b_ff <= abs_ey;
      end else if (cmd.mul_step) begin
         if (mul_b_ff[0]) prod_ff <= prod_ff + mul_a_ff;
         mul_a_ff <= {mul_a_ff[94:0], 1'b0};
         mul_b_ff <= {1'b0, mul_b_ff[47:1]};
      end

      // twin restoring dividers sharing one divisor
      if (cmd.div_ld_chg) begin
         dvdx_ff <= {numx_ff[31:0], 32'd0};
         dvdy_ff <= {numy_ff[31:0], 32'd0};
         dvs_ff  <= prod_ff[63:0];
         remx_ff <= '0;
         remy_ff <= '0;
      end else if (cmd.div_ld_dir) begin
         dvdx_ff <= {1'b0, abs_ex, 15'd0};
         dvdy_ff <= {1'b0, abs_ey, 15'd0};
         dvs_ff  <= {17'd0, mag_ff};
         remx_ff <= '0;
         remy_ff <= '0;
      end else if (cmd.div_step) begin
         remx_ff <= gex ? remx_t - dvs_ff : remx_t;
         remy_ff <= gey ? remy_t - dvs_ff : remy_t;
         dvdx_ff <= {dvdx_ff[62:0], gex};
         dvdy_ff <= {dvdy_ff[62:0], gey};
      end

      if (cmd.acc) begin
         accx_ff <= accx_ff + tx;
         accy_ff <= accy_ff + ty;
      end
      if (cmd.sat) begin
         ex_ff <= sat48(accx_ff);
         ey_ff <= sat48(accy_ff);
      end
      if (cmd.mag_ld) begin
         mag_ff <= sq_root_ff[47] ? '1 : sq_root_ff[46:0];
      end

      if (cmd.out_ld) begin
         rsp_field_x      <= ex_ff;
         rsp_field_y      <= ey_ff;
         rsp_field_mag    <= mag_ff;
         rsp_dir_cos      <= dir_q15(ex_ff[47], dvdx_ff, mag_ff == '0);
         rsp_dir_sin      <= dir_q15(ey_ff[47], dvdy_ff, mag_ff == '0);
         rsp_singular     <= sing_ff;
         rsp_near_pos_hit <= phit_ff;
         rsp_near_pos_x   <= phx_ff;
         rsp_near_pos_y   <= phy_ff;
         rsp_near_neg_hit <= nhit_ff;
         rsp_near_neg_x   <= nhx_ff;
         rsp_near_neg_y   <= nhy_ff;
      end
   end

   assign stat.r2_zero  = (r2_ff == '0);
   assign stat.mag_zero = (mag_ff == '0);
endmodule

### rtl/core/pce_ctrl.sv
// Controller: table counts, scan sequencing and step counting for the datapath.
module pce_ctrl import pce_pkg::*; #(
   parameter int MAX_CHARGES = 32,
   localparam int AW = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1,
   localparam int CW = $clog2(MAX_CHARGES + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [1:0]    req_mode,
   input  logic          req_to_negative,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  stat_type      stat,
   output cmd_type       cmd,
   output logic [AW-1:0] wr_addr,
   output logic [AW-1:0] rd_addr
);
   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_CHK  = 5'd1;
   localparam logic [4:0] S_RD   = 5'd2;
   localparam logic [4:0] S_LD   = 5'd3;
   localparam logic [4:0] S_SQ1  = 5'd4;
   localparam logic [4:0] S_SQ2  = 5'd5;
   localparam logic [4:0] S_SQL  = 5'd6;
   localparam logic [4:0] S_SQRT = 5'd7;
   localparam logic [4:0] S_MULL = 5'd8;
   localparam logic [4:0] S_MUL  = 5'd9;
   localparam logic [4:0] S_DIVL = 5'd10;
   localparam logic [4:0] S_DIV  = 5'd11;
   localparam logic [4:0] S_ACC  = 5'd12;
   localparam logic [4:0] S_SAT  = 5'd13;
   localparam logic [4:0] S_HXL  = 5'd14;
   localparam logic [4:0] S_HX   = 5'd15;
   localparam logic [4:0] S_HYL  = 5'd16;
   localparam logic [4:0] S_HY   = 5'd17;
   localparam logic [4:0] S_HSL  = 5'd18;
   localparam logic [4:0] S_HS   = 5'd19;
   localparam logic [4:0] S_MAG  = 5'd20;
   localparam logic [4:0] S_MZ   = 5'd21;
   localparam logic [4:0] S_DDV  = 5'd22;
   localparam logic [4:0] S_OUT  = 5'd23;

   localparam logic [CW-1:0] MAXC = CW'(MAX_CHARGES);

   logic [4:0]    state_ff, state_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [CW-1:0] pcnt_ff, pcnt_in, ncnt_ff, ncnt_in, idx_ff, idx_in;
   logic          tbl_ff, tbl_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          req_xfer, slot_free, last;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign last      = (cnt_ff == '0);
   assign wr_addr   = req_to_negative ? ncnt_ff[AW-1:0] : pcnt_ff[AW-1:0];
   assign rd_addr   = idx_ff[AW-1:0];
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = last ? cnt_ff : cnt_ff - 6'd1;
      pcnt_in  = pcnt_ff;
      ncnt_in  = ncnt_ff;
      idx_in   = idx_ff;
      tbl_in   = tbl_ff;
      cmd      = '0;
      cmd.tbl  = tbl_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               case (req_mode)
                  MODE_CLEAR: begin
                     pcnt_in = '0;
                     ncnt_in = '0;
                  end
                  MODE_ADD: begin
                     if (req_to_negative && ncnt_ff < MAXC) begin
                        cmd.wr_neg = 1'b1;
                        ncnt_in    = ncnt_ff + 1'b1;
                     end
                     if (!req_to_negative && pcnt_ff < MAXC) begin
                        cmd.wr_pos = 1'b1;
                        pcnt_in    = pcnt_ff + 1'b1;
                     end
                  end
                  MODE_QUERY: begin
                     cmd.q_start = 1'b1;
                     idx_in   = '0;
                     tbl_in   = 1'b0;
                     state_in = S_CHK;
                  end
                  default: ;
               endcase
            end
         end
         S_CHK: begin
            if (!tbl_ff) begin
               if (idx_ff < pcnt_ff) begin
                  state_in = S_RD;
               end else begin
                  tbl_in = 1'b1;
                  idx_in = '0;
               end
            end else if (idx_ff < ncnt_ff) begin
               state_in = S_RD;
            end else begin
               state_in = S_SAT;
            end
         end
         S_RD:  state_in = S_LD;
         S_LD: begin
            cmd.ld   = 1'b1;
            state_in = S_SQ1;
         end
         S_SQ1: begin
            cmd.sq1  = 1'b1;
            state_in = S_SQ2;
         end
         S_SQ2: begin
            cmd.sq2  = 1'b1;
            state_in = S_SQL;
         end
         S_SQL: begin
            // coincident charge contributes nothing
            if (stat.r2_zero) begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_CHK;
            end else begin
               cmd.sqrt_ld_chg = 1'b1;
               cnt_in   = 6'(SQRT_STEPS - 1);
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (last) state_in = S_MULL;
         end
         S_MULL: begin
            cmd.mul_ld_chg = 1'b1;
            cnt_in   = 6'(MUL_STEPS - 1);
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            if (last) state_in = S_DIVL;
         end
         S_DIVL: begin
            cmd.div_ld_chg = 1'b1;
            cnt_in   = 6'(DIV_STEPS - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (last) state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            idx_in   = idx_ff + 1'b1;
            state_in = S_CHK;
         end
         S_SAT: begin
            cmd.sat  = 1'b1;
            state_in = S_HXL;
         end
         S_HXL: begin
            cmd.mul_ld_hx = 1'b1;
            cnt_in   = 6'(MUL_STEPS - 1);
            state_in = S_HX;
         end
         S_HX: begin
            cmd.mul_step = 1'b1;
            if (last) state_in = S_HYL;
         end
         S_HYL: begin
            cmd.mul_ld_hy = 1'b1;
            cnt_in   = 6'(MUL_STEPS - 1);
            state_in = S_HY;
         end
         S_HY: begin
            cmd.mul_step = 1'b1;
            if (last) state_in = S_HSL;
         end
         S_HSL: begin
            cmd.sqrt_ld_hyp = 1'b1;
            cnt_in   = 6'(SQRT_STEPS - 1);
            state_in = S_HS;
         end
         S_HS: begin
            cmd.sqrt_step = 1'b1;
            if (last) state_in = S_MAG;
         end
         S_MAG: begin
            cmd.mag_ld = 1'b1;
            state_in   = S_MZ;
         end
         S_MZ: begin
            if (stat.mag_zero) begin
               state_in = S_OUT;
            end else begin
               cmd.div_ld_dir = 1'b1;
               cnt_in   = 6'(DIV_STEPS - 1);
               state_in = S_DDV;
            end
         end
         S_DDV: begin
            cmd.div_step = 1'b1;
            if (last) state_in = S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               cmd.out_ld   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pcnt_ff      <= '0;
         ncnt_ff      <= '0;
         idx_ff       <= '0;
         tbl_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pcnt_ff      <= pcnt_in;
         ncnt_ff      <= ncnt_in;
         idx_ff       <= idx_in;
         tbl_ff       <= tbl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      pcnt_ff <= MAXC && ncnt_ff <= MAXC)
      else $error("charge count beyond table depth");

   a_query_start: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_mode == MODE_QUERY |=> state_ff == S_CHK && idx_ff == '0)
      else $error("query transfer did not start a scan");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RD |-> idx_ff < (tbl_ff ? ncnt_ff : pcnt_ff))
      else $error("table read beyond fill count");

   a_out_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT && rsp_valid_ff && rsp_stall |=> state_ff == S_OUT && rsp_valid_ff)
      else $error("result overwritten while stalled");
endmodule

### rtl/core/point_charge_field_evaluator.sv
// Top level of the point charge field evaluator.
// Input channel req_*: one item per transfer (req_valid high, req_stall low).
//   mode clear empties both charge tables, mode add appends a charge to the
//   table picked by req_to_negative (dropped when full).
//   mode query evaluates the field at (req_pos_x, req_pos_y) and yields one
//   result on the rsp_* channel; unused mode codes are dropped.
// Query: for each of the N stored charges, the scan runs a 48-step square root,
//   a 48-step shift-add multiply and a 64-step divide pair on shared
//   iterative units. A coincident charge skips all three, and a zero field
//   skips the final 64-step divide. req_stall stays high for the whole query.
// Result channel rsp_*: held in an output register; a new item can be taken
//   while a result waits. A finished query waits while the receiver stalls
//   and the held result is pending.
// csr channel: writes near_radius; csr_ready is always high. Write only idle.
// Reset (synchronous): both tables empty, near_radius = 10, no result pending.
module point_charge_field_evaluator import pce_pkg::*; #(
   parameter int MAX_CHARGES = 32,
   localparam int AW = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [9:0]         csr_near_radius,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic               req_to_negative,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_charge_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [47:0] rsp_field_x,
   output logic signed [47:0] rsp_field_y,
   output logic [46:0]        rsp_field_mag,
   output logic signed [15:0] rsp_dir_cos,
   output logic signed [15:0] rsp_dir_sin,
   output logic               rsp_singular,
   output logic               rsp_near_pos_hit,
   output logic signed [15:0] rsp_near_pos_x,
   output logic signed [15:0] rsp_near_pos_y,
   output logic               rsp_near_neg_hit,
   output logic signed [15:0] rsp_near_neg_x,
   output logic signed [15:0] rsp_near_neg_y
);
   cmd_type       cmd;
   stat_type      stat;
   logic [AW-1:0] wr_addr, rd_addr;

   assign csr_ready = 1'b1;

   pce_ctrl #(.MAX_CHARGES(MAX_CHARGES)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_mode(req_mode), .req_to_negative(req_to_negative),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .stat(stat), .cmd(cmd), .wr_addr(wr_addr), .rd_addr(rd_addr)
   );

   pce_datapath #(.MAX_CHARGES(MAX_CHARGES)) u_dp (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_near_radius(csr_near_radius),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_charge_value(req_charge_value),
      .cmd(cmd), .wr_addr(wr_addr), .rd_addr(rd_addr), .stat(stat),
      .rsp_field_x(rsp_field_x), .rsp_field_y(rsp_field_y),
      .rsp_field_mag(rsp_field_mag),
      .rsp_dir_cos(rsp_dir_cos), .rsp_dir_sin(rsp_dir_sin),
      .rsp_singular(rsp_singular),
      .rsp_near_pos_hit(rsp_near_pos_hit),
      .rsp_near_pos_x(rsp_near_pos_x), .rsp_near_pos_y(rsp_near_pos_y),
      .rsp_near_neg_hit(rsp_near_neg_hit),
      .rsp_near_neg_x(rsp_near_neg_x), .rsp_near_neg_y(rsp_near_neg_y)
   );
endmodule
